[rtl/core/nearest_manhattan_point_search_core_assert.svh]
// Assertion macros shared by the nearest Manhattan point search RTL.
`ifndef NEAREST_MANHATTAN_POINT_SEARCH_CORE_ASSERT_SVH
`define NEAREST_MANHATTAN_POINT_SEARCH_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define NMPS_ASSERT_NOW(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define NMPS_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

[rtl/core/nmps_pkg.sv]
// Package with sizes, types and state codes of the nearest Manhattan point search.
package nmps_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int COORD_BITS = 20;

    localparam int FIELD_W = 20;
    localparam int DIST_W  = 21;

    // Coordinate bits actually kept: the field is masked to COORD_BITS.
    localparam int CW     = (COORD_BITS < FIELD_W) ? COORD_BITS : FIELD_W;
    localparam int SUM_W  = CW + 1;
    localparam int MEM_W  = 2 * CW;
    localparam int AW     = $clog2(MAX_POINTS);
    localparam int CNT_W  = $clog2(MAX_POINTS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } t_state;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_QUERY  = 1'b1
    } t_op;

    // Tag issued alongside each store read during a scan.
    typedef struct packed {
        logic valid;
        logic first;
    } t_scan_ctl;

    // Status returned by the distance unit.
    typedef struct packed {
        logic             busy;
        logic [SUM_W-1:0] best;
    } t_dist_stat;

    // Result word offered by the sequencer to the output register.
    typedef struct packed {
        logic              valid;
        logic [DIST_W-1:0] distance;
        logic              found;
        logic              overflow;
    } t_result;

endpackage

[rtl/core/nmps_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module nmps_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/nmps_dist.sv]
// Shared distance unit: absolute differences, then sum and running minimum.
module nmps_dist
    import nmps_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_scan_ctl        i_scan,
    input  logic [MEM_W-1:0] i_point,
    input  logic [CW-1:0]    i_qx,
    input  logic [CW-1:0]    i_qy,
    output t_dist_stat       o_stat
);

    logic             r_v0;
    logic             r_first0;
    logic             r_v1;
    logic             r_first1;
    logic [CW-1:0]    r_dx;
    logic [CW-1:0]    r_dy;
    logic [SUM_W-1:0] r_best;

    logic [CW-1:0]    px;
    logic [CW-1:0]    py;
    logic [CW-1:0]    n_dx;
    logic [CW-1:0]    n_dy;
    logic [SUM_W-1:0] sum;

    assign px = i_point[CW-1:0];
    assign py = i_point[MEM_W-1:CW];

    always_comb begin
        n_dx = (px >= i_qx) ? (px - i_qx) : (i_qx - px);
        n_dy = (py >= i_qy) ? (py - i_qy) : (i_qy - py);
        sum  = {1'b0, r_dx} + {1'b0, r_dy};
    end

    // The tag is registered to line up with the registered read data, and again to line up with the differences.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
        end else begin
            r_v0 <= i_scan.valid;
            r_v1 <= r_v0;
        end
        r_first0 <= i_scan.first;
        r_first1 <= r_first0;
        if (r_v0) begin
            r_dx <= n_dx;
            r_dy <= n_dy;
        end
        if (r_v1 && (r_first1 || (sum < r_best))) begin
            r_best <= sum;
        end
    end

    assign o_stat.busy = r_v0 | r_v1;
    assign o_stat.best = r_best;

endmodule

[rtl/core/nmps_ctrl.sv]
// Sequencer: takes words, writes inserts to the store and walks it for queries.
module nmps_ctrl
    import nmps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic [FIELD_W-1:0] i_coord_x,
    input  logic [FIELD_W-1:0] i_coord_y,
    output logic               o_wr_en,
    output logic [AW-1:0]      o_waddr,
    output logic [MEM_W-1:0]   o_wdata,
    output logic               o_rd_en,
    output logic [AW-1:0]      o_raddr,
    output t_scan_ctl          o_scan,
    output logic [CW-1:0]      o_qx,
    output logic [CW-1:0]      o_qy,
    input  t_dist_stat         i_dist,
    output t_result            o_result,
    input  logic               i_result_take,
    output logic [CNT_W-1:0]   o_count
);

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_addr;
    logic [CW-1:0]    r_qx;
    logic [CW-1:0]    r_qy;
    logic             r_res_found;
    logic             r_res_ovf;

    logic accept;
    logic has_room;
    logic scan_last;

    assign has_room  = (r_count < CNT_W'(MAX_POINTS));
    assign accept    = i_valid && (r_state == ST_IDLE);
    assign scan_last = ((r_addr + CNT_W'(1)) == r_count);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if ((i_op == OP_QUERY) && (r_count != '0)) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_RESULT;
                    end
                end
            end
            ST_SCAN: begin
                if (scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_dist.busy) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (i_result_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_ready           = 1'b0;
        o_wr_en           = 1'b0;
        o_rd_en           = 1'b0;
        o_scan            = '0;
        o_result.valid    = 1'b0;
        o_result.distance = r_res_found ? DIST_W'(i_dist.best) : '0;
        o_result.found    = r_res_found;
        o_result.overflow = r_res_ovf;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                o_wr_en = accept && (i_op == OP_INSERT) && has_room;
            end
            ST_SCAN: begin
                o_rd_en      = 1'b1;
                o_scan.valid = 1'b1;
                o_scan.first = (r_addr == '0);
            end
            ST_DRAIN: begin
                o_rd_en = 1'b0;
            end
            ST_RESULT: begin
                o_result.valid = 1'b1;
            end
            default: o_ready = 1'b0;
        endcase
    end

    assign o_waddr = r_count[AW-1:0];
    assign o_wdata = {i_coord_y[CW-1:0], i_coord_x[CW-1:0]};
    assign o_raddr = r_addr[AW-1:0];
    assign o_qx    = r_qx;
    assign o_qy    = r_qy;
    assign o_count = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (o_wr_en) begin
                r_count <= r_count + CNT_W'(1);
            end
        end
        if (accept) begin
            r_addr      <= '0;
            r_qx        <= i_coord_x[CW-1:0];
            r_qy        <= i_coord_y[CW-1:0];
            r_res_found <= (i_op == OP_QUERY) && (r_count != '0);
            r_res_ovf   <= (i_op == OP_INSERT) && !has_room;
        end else if (r_state == ST_SCAN) begin
            r_addr <= r_addr + CNT_W'(1);
        end
    end

endmodule

[rtl/core/nearest_manhattan_point_search_core.sv]
// Nearest Manhattan point search: store of up to MAX_POINTS 2-D points. An
// insert word goes straight to the result state. A query word walks the store
// through its single read port, one stored point per cycle, then drains the
// distance pipeline before its result; a query on an empty store goes straight
// to the result. The block takes one word at a time; a finished result waits
// in the output register while the next word is taken. The point count is
// cleared by reset and no clearing pass is needed.
module nearest_manhattan_point_search_core
    import nmps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_op,
    input  logic [FIELD_W-1:0] i_coord_x,
    input  logic [FIELD_W-1:0] i_coord_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [DIST_W-1:0]  o_distance,
    output logic               o_found,
    output logic               o_overflow
);

`include "nearest_manhattan_point_search_core_assert.svh"

    logic             wr_en;
    logic [AW-1:0]    waddr;
    logic [MEM_W-1:0] wdata;
    logic             rd_en;
    logic [AW-1:0]    raddr;
    logic [MEM_W-1:0] rdata;
    t_scan_ctl        scan;
    logic [CW-1:0]    qx;
    logic [CW-1:0]    qy;
    t_dist_stat       dist_stat;
    t_result          result;
    logic             result_take;
    logic [CNT_W-1:0] count;

    logic              r_out_valid;
    logic [DIST_W-1:0] r_out_distance;
    logic              r_out_found;
    logic              r_out_overflow;

    nmps_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_op          (i_op),
        .i_coord_x     (i_coord_x),
        .i_coord_y     (i_coord_y),
        .o_wr_en       (wr_en),
        .o_waddr       (waddr),
        .o_wdata       (wdata),
        .o_rd_en       (rd_en),
        .o_raddr       (raddr),
        .o_scan        (scan),
        .o_qx          (qx),
        .o_qy          (qy),
        .i_dist        (dist_stat),
        .o_result      (result),
        .i_result_take (result_take),
        .o_count       (count)
    );

    nmps_ram #(
        .W     (MEM_W),
        .DEPTH (MAX_POINTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    nmps_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scan  (scan),
        .i_point (rdata),
        .i_qx    (qx),
        .i_qy    (qy),
        .o_stat  (dist_stat)
    );

    // The output register is free when empty or when its word leaves this cycle.
    assign result_take = result.valid && (!r_out_valid || i_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (result_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
        if (result_take) begin
            r_out_distance <= result.distance;
            r_out_found    <= result.found;
            r_out_overflow <= result.overflow;
        end
    end

    assign o_valid    = r_out_valid;
    assign o_distance = r_out_distance;
    assign o_found    = r_out_found;
    assign o_overflow = r_out_overflow;

    `NMPS_ASSERT_NOW(a_count_in_range, i_clk, i_rst_n, 1'b1, count <= CNT_W'(MAX_POINTS), "point count beyond store depth")
    `NMPS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && o_ready, !o_ready, "word taken while a word is in progress")
    `NMPS_ASSERT_NOW(a_flags_exclusive, i_clk, i_rst_n, o_valid, !(o_found && o_overflow), "found and overflow both set")
    `NMPS_ASSERT_NOW(a_distance_zero, i_clk, i_rst_n, o_valid && !o_found, o_distance == '0, "distance set without a found point")

endmodule
